/* rtl/nor_flash_command_sequencer_assert.svh */
// assertion macros shared by the sequencer rtl
// no dependencies; included by the modules that check themselves
`ifndef NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define NFCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nfcs: assertion failed");

// next-cycle implication, disabled while in reset
`define NFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nfcs: assertion failed");

`endif

/* rtl/nfcs_pkg.sv */
// types, codes and the command step table of the nor flash command sequencer
// no dependencies; used by every module of the block
`default_nettype none

package nfcs_pkg;

	localparam int unsigned JOBQ_DEPTH = 4;
	localparam int unsigned OFF_W = 12;
	localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;

	localparam logic REG_FLASH_BASE = 1'b0;
	localparam logic REG_POLL_LIMIT = 1'b1;

	localparam logic [OFF_W-1:0] OFF_ZERO = 12'h000;
	localparam logic [OFF_W-1:0] OFF_555 = 12'h555;
	localparam logic [OFF_W-1:0] OFF_2AA = 12'h2AA;

	localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
	localparam logic [7:0] CMD_AUTOSELECT = 8'h90;
	localparam logic [7:0] CMD_READ_ARRAY = 8'hF0;
	localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
	localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_BYPASS_ENTER = 8'h20;
	localparam logic [7:0] CMD_BYPASS_EXIT2 = 8'h00;
	localparam logic [7:0] MAKER_ID_OK = 8'h01;
	localparam logic [7:0] DEV_ID_BYPASS = 8'h4F;
	localparam logic [7:0] DEV_ID_PLAIN = 8'hA4;

	// first step of a sequence
	localparam logic [3:0] START_FULL = 4'd0;
	localparam logic [3:0] START_NO_EXIT = 4'd2;
	localparam logic [3:0] START_PROG_BYPASS = 4'd3;
	localparam logic [3:0] START_DONE_ONLY = 4'd3;
	// standard program skips the bypass entry step after this one
	localparam logic [3:0] PROG_SKIP_FROM = 4'd1;

	typedef enum logic [2:0] {
		OP_IDENTIFY  = 3'd0,
		OP_PROGRAM   = 3'd1,
		OP_ERASE     = 3'd2,
		OP_RESET     = 3'd3,
		OP_READ_DATA = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAKER = 2'd1,
		ST_TIMEOUT   = 2'd2,
		ST_DQ5       = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_ID_MID     = 5'b00010,
		PH_ID_DID     = 5'b00100,
		PH_POLL_PROG  = 5'b01000,
		PH_POLL_ERASE = 5'b10000
	} phase_t;

	typedef enum logic [4:0] {
		SEQ_ID     = 5'b00001,
		SEQ_PROG   = 5'b00010,
		SEQ_ERASE  = 5'b00100,
		SEQ_FINISH = 5'b01000,
		SEQ_READ   = 5'b10000
	} seq_t;

	typedef enum logic [1:0] {
		ASEL_BASE = 2'd0,
		ASEL_JOB  = 2'd1,
		ASEL_ZERO = 2'd2
	} asel_t;

	typedef struct packed {
		seq_t        seq;
		logic [3:0]  start;
		logic        skip;
		logic [31:0] addr;
		logic [7:0]  data;
		status_t     status;
	} job_t;

	typedef struct packed {
		kind_t           kind;
		asel_t           asel;
		logic [OFF_W-1:0] off;
		logic            djob;
		logic [7:0]      dconst;
		logic            last;
	} micro_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [7:0]  data;
		status_t     status;
		logic        last;
	} result_t;

	function automatic micro_t mk(kind_t kind, asel_t asel, logic [OFF_W-1:0] off,
		logic djob, logic [7:0] dconst, logic last);
		micro_t m;
		m.kind = kind;
		m.asel = asel;
		m.off = off;
		m.djob = djob;
		m.dconst = dconst;
		m.last = last;
		return m;
	endfunction

	function automatic micro_t bw(logic [OFF_W-1:0] off, logic [7:0] d);
		return mk(KIND_WRITE, ASEL_BASE, off, 1'b0, d, 1'b0);
	endfunction

	function automatic micro_t job_read();
		return mk(KIND_READ, ASEL_JOB, OFF_ZERO, 1'b0, 8'h00, 1'b1);
	endfunction

	function automatic micro_t done();
		return mk(KIND_DONE, ASEL_ZERO, OFF_ZERO, 1'b1, 8'h00, 1'b1);
	endfunction

	function automatic micro_t nfcs_micro(seq_t seq, logic [3:0] step);
		micro_t m;
		m = done();
		case (seq)
			SEQ_ID: begin
				case (step)
					4'd0: m = bw(OFF_ZERO, CMD_READ_ARRAY);
					4'd1: m = bw(OFF_555, CMD_UNLOCK1);
					4'd2: m = bw(OFF_2AA, CMD_UNLOCK2);
					4'd3: m = bw(OFF_555, CMD_AUTOSELECT);
					default: m = mk(KIND_READ, ASEL_BASE, OFF_ZERO, 1'b0, 8'h00, 1'b1);
				endcase
			end
			SEQ_PROG: begin
				case (step)
					4'd0: m = bw(OFF_555, CMD_UNLOCK1);
					4'd1: m = bw(OFF_2AA, CMD_UNLOCK2);
					4'd2: m = bw(OFF_555, CMD_BYPASS_ENTER);
					4'd3: m = bw(OFF_555, CMD_PROGRAM);
					4'd4: m = mk(KIND_WRITE, ASEL_JOB, OFF_ZERO, 1'b1, 8'h00, 1'b0);
					default: m = job_read();
				endcase
			end
			SEQ_ERASE: begin
				case (step)
					4'd0: m = bw(OFF_555, CMD_AUTOSELECT);
					4'd1: m = bw(OFF_2AA, CMD_BYPASS_EXIT2);
					4'd2: m = bw(OFF_ZERO, CMD_READ_ARRAY);
					4'd3: m = bw(OFF_555, CMD_UNLOCK1);
					4'd4: m = bw(OFF_2AA, CMD_UNLOCK2);
					4'd5: m = bw(OFF_555, CMD_ERASE_SETUP);
					4'd6: m = bw(OFF_555, CMD_UNLOCK1);
					4'd7: m = bw(OFF_2AA, CMD_UNLOCK2);
					4'd8: m = mk(KIND_WRITE, ASEL_JOB, OFF_ZERO, 1'b0, CMD_SECTOR_ERASE, 1'b0);
					default: m = job_read();
				endcase
			end
			SEQ_FINISH: begin
				case (step)
					4'd0: m = bw(OFF_555, CMD_AUTOSELECT);
					4'd1: m = bw(OFF_2AA, CMD_BYPASS_EXIT2);
					4'd2: m = bw(OFF_ZERO, CMD_READ_ARRAY);
					default: m = done();
				endcase
			end
			SEQ_READ: m = job_read();
			default: m = done();
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/nfcs_jobq.sv */
// short job queue between the request front end and the bus cycle back end
// depends on nfcs_pkg and the assertion macro header
`default_nettype none
`include "nor_flash_command_sequencer_assert.svh"

module nfcs_jobq #(
	parameter int unsigned DEPTH = nfcs_pkg::JOBQ_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nfcs_pkg::job_t  wjob,
	output logic            full,
	input  logic            pop,
	output nfcs_pkg::job_t  rjob,
	output logic            empty
);
	import nfcs_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rjob = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wjob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	`NFCS_ASSERT_IMPL(a_jobq_no_overflow, clk, arst_n, push, !full)
	`NFCS_ASSERT_IMPL(a_jobq_no_underflow, clk, arst_n, pop, !empty)
	`NFCS_ASSERT_NEXT(a_jobq_count, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

`default_nettype wire

/* rtl/nfcs_front.sv */
// request front end: accepts items, tracks the flash protocol phase and polling,
// and turns each item that fits the phase into a job for the back end; depends on nfcs_pkg
`default_nettype none

module nfcs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            jq_full,
	input  logic [2:0]      operation,
	input  logic [31:0]     target_address,
	input  logic [7:0]      write_data,
	input  logic [7:0]      read_data,
	input  logic [31:0]     flash_base,
	input  logic [15:0]     poll_limit,
	output logic            job_push,
	output nfcs_pkg::job_t  job
);
	import nfcs_pkg::*;

	phase_t      phase_q, phase_d;
	logic        bypass_active_q, bypass_active_d;
	logic        bypass_algo_q, bypass_algo_d;
	logic        expected_dq7_q, expected_dq7_d;
	logic [15:0] poll_count_q, poll_count_d;
	logic        after_dq5_q, after_dq5_d;
	logic [31:0] poll_addr_q, poll_addr_d;
	logic [7:0]  maker_id_q, maker_id_d;

	logic        accept;
	logic        match;
	logic [15:0] count_inc;
	logic [31:0] base_plus1;
	logic        finish;
	status_t     fin_st;

	assign accept = push && !jq_full;
	assign match = (read_data[7] == expected_dq7_q);
	assign count_inc = poll_count_q + 16'd1;
	assign base_plus1 = flash_base + 32'd1;

	always_comb begin
		phase_d = phase_q;
		bypass_active_d = bypass_active_q;
		bypass_algo_d = bypass_algo_q;
		expected_dq7_d = expected_dq7_q;
		poll_count_d = poll_count_q;
		after_dq5_d = after_dq5_q;
		poll_addr_d = poll_addr_q;
		maker_id_d = maker_id_q;
		job_push = 1'b0;
		job.seq = SEQ_READ;
		job.start = START_FULL;
		job.skip = 1'b0;
		job.addr = target_address;
		job.data = 8'h00;
		job.status = ST_OK;
		finish = 1'b0;
		fin_st = ST_OK;
		if (accept) begin
			case (op_t'(operation))
				OP_IDENTIFY: begin
					if (phase_q == PH_IDLE) begin
						job_push = 1'b1;
						job.seq = SEQ_ID;
						phase_d = PH_ID_MID;
					end
				end
				OP_PROGRAM: begin
					if (phase_q == PH_IDLE) begin
						job_push = 1'b1;
						job.seq = SEQ_PROG;
						job.data = write_data;
						job.skip = !bypass_algo_q;
						if (bypass_algo_q && bypass_active_q) begin
							job.start = START_PROG_BYPASS;
						end
						if (bypass_algo_q) begin
							bypass_active_d = 1'b1;
						end
						expected_dq7_d = write_data[7];
						poll_count_d = '0;
						after_dq5_d = 1'b0;
						poll_addr_d = target_address;
						phase_d = PH_POLL_PROG;
					end
				end
				OP_ERASE: begin
					if (phase_q == PH_IDLE) begin
						job_push = 1'b1;
						job.seq = SEQ_ERASE;
						job.start = bypass_active_q ? START_FULL : START_NO_EXIT;
						bypass_active_d = 1'b0;
						expected_dq7_d = 1'b1;
						poll_count_d = '0;
						after_dq5_d = 1'b0;
						poll_addr_d = target_address;
						phase_d = PH_POLL_ERASE;
					end
				end
				OP_RESET: begin
					if (phase_q == PH_IDLE) begin
						job_push = 1'b1;
						job.seq = SEQ_FINISH;
						job.start = bypass_active_q ? START_FULL : START_NO_EXIT;
						bypass_active_d = 1'b0;
					end
				end
				OP_READ_DATA: begin
					case (phase_q)
						PH_ID_MID: begin
							maker_id_d = read_data;
							job_push = 1'b1;
							job.seq = SEQ_READ;
							job.addr = base_plus1;
							phase_d = PH_ID_DID;
						end
						PH_ID_DID: begin
							job_push = 1'b1;
							job.seq = SEQ_FINISH;
							job.start = START_NO_EXIT;
							job.data = read_data;
							if (maker_id_q != MAKER_ID_OK) begin
								job.status = ST_BAD_MAKER;
							end else if (read_data == DEV_ID_BYPASS) begin
								bypass_algo_d = 1'b1;
							end
							phase_d = PH_IDLE;
						end
						PH_POLL_PROG, PH_POLL_ERASE: begin
							job_push = 1'b1;
							job.addr = poll_addr_q;
							if (after_dq5_q) begin
								finish = 1'b1;
								fin_st = match ? ST_OK : ST_DQ5;
							end else if (match) begin
								finish = 1'b1;
							end else if (read_data[5]) begin
								after_dq5_d = 1'b1;
							end else begin
								poll_count_d = count_inc;
								if (count_inc >= poll_limit || count_inc == '0) begin
									finish = 1'b1;
									fin_st = ST_TIMEOUT;
								end
							end
							if (finish) begin
								job.seq = SEQ_FINISH;
								job.status = fin_st;
								if (phase_q == PH_POLL_ERASE) begin
									job.start = bypass_active_q ? START_FULL : START_NO_EXIT;
									bypass_active_d = 1'b0;
								end else begin
									job.start = START_DONE_ONLY;
								end
								phase_d = PH_IDLE;
								after_dq5_d = 1'b0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bypass_active_q <= 1'b0;
			bypass_algo_q <= 1'b0;
			expected_dq7_q <= 1'b0;
			poll_count_q <= '0;
			after_dq5_q <= 1'b0;
			poll_addr_q <= '0;
			maker_id_q <= '0;
		end else begin
			phase_q <= phase_d;
			bypass_active_q <= bypass_active_d;
			bypass_algo_q <= bypass_algo_d;
			expected_dq7_q <= expected_dq7_d;
			poll_count_q <= poll_count_d;
			after_dq5_q <= after_dq5_d;
			poll_addr_q <= poll_addr_d;
			maker_id_q <= maker_id_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/nfcs_back.sv */
// bus cycle back end: steps through each job's command table and queues one result
// item per cycle while its result queue has room; depends on nfcs_pkg and the assertion macro header
`default_nettype none
`include "nor_flash_command_sequencer_assert.svh"

module nfcs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        flash_base,
	input  nfcs_pkg::job_t     jq_job,
	input  logic               jq_empty,
	output logic               jq_pop,
	input  logic               pop,
	output logic               empty,
	output nfcs_pkg::result_t  res
);
	import nfcs_pkg::*;

	job_t       cur_job_q;
	logic [3:0] step_q;
	logic       busy_q;
	result_t    ofifo_q [2];
	logic       owp_q;
	logic       orp_q;
	logic [1:0] ocnt_q;

	micro_t     m;
	result_t    item;
	logic       emit;
	logic       load;
	logic       opop;
	logic [3:0] step_nx;

	always_comb begin
		m = nfcs_micro(cur_job_q.seq, step_q);
		item.kind = m.kind;
		case (m.asel)
			ASEL_BASE: item.addr = flash_base + 32'(m.off);
			ASEL_JOB: item.addr = cur_job_q.addr;
			default: item.addr = '0;
		endcase
		item.data = m.djob ? cur_job_q.data : m.dconst;
		item.status = (m.kind == KIND_DONE) ? cur_job_q.status : ST_OK;
		item.last = m.last;
	end

	assign step_nx = (cur_job_q.seq == SEQ_PROG && cur_job_q.skip && step_q == PROG_SKIP_FROM)
		? step_q + 4'd2 : step_q + 4'd1;
	assign emit = busy_q && (ocnt_q != 2'd2);
	assign load = !jq_empty && (!busy_q || (emit && item.last));
	assign jq_pop = load;
	assign empty = (ocnt_q == 2'd0);
	assign opop = pop && !empty;
	assign res = ofifo_q[orp_q];

	always_ff @(posedge clk) begin
		if (load) begin
			cur_job_q <= jq_job;
		end
		if (emit) begin
			ofifo_q[owp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (load) begin
				step_q <= jq_job.start;
				busy_q <= 1'b1;
			end else if (emit) begin
				step_q <= step_nx;
				if (item.last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				owp_q <= !owp_q;
			end
			if (opop) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + 2'(emit) - 2'(opop);
		end
	end

	`NFCS_ASSERT_IMPL(a_back_ocnt_range, clk, arst_n, 1'b1, ocnt_q != 2'd3)
	`NFCS_ASSERT_IMPL(a_back_done_is_last, clk, arst_n, emit && item.kind == KIND_DONE, item.last)
	`NFCS_ASSERT_NEXT(a_back_step_holds, clk, arst_n, busy_q && !emit && !load, $stable(step_q))

endmodule

`default_nettype wire

/* rtl/nor_flash_command_sequencer.sv */
// nor flash command sequencer: unlock/command cycles and dq7/dq5 data polling
// top level; depends on nfcs_pkg, nfcs_jobq, nfcs_front and nfcs_back
//
// Requests enter on a queue-like port (push/full): identify, program byte,
// erase sector, read-array reset, and read data answering the last bus read.
// Results leave on a queue-like port (empty/pop): bus write cycles, bus read
// cycles and completion reports when an operation ends, the final one of each input
// flagged by last. A read cycle asks the host to push the data it returned.
// The front end takes an item every cycle while its job queue has room; the
// back end emits one result per cycle while its result queue has room, at most
// ten results for one input (an erase leaving bypass mode). The first result of an
// item is registered in the job queue, the back end's job and the result queue.
// If the receiver stops popping, the two-entry result queue fills, the back
// end stops, then the job queue fills and full rises; nothing is lost.
// Reset clears the protocol phase, bypass mode and the queues, and loads
// flash_base 0 and poll_limit 1000; cfg_we writes a register at the next edge.

`default_nettype none

module nor_flash_command_sequencer #(
	parameter int unsigned JOB_DEPTH = nfcs_pkg::JOBQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [31:0] target_address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  read_data,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  cycle_kind,
	output logic [31:0] bus_address,
	output logic [7:0]  bus_data,
	output logic [1:0]  status,
	output logic        last
);
	import nfcs_pkg::*;

	logic [31:0] flash_base_q;
	logic [15:0] poll_limit_q;

	logic    job_push;
	job_t    job_in;
	job_t    job_out;
	logic    jq_full;
	logic    jq_empty;
	logic    jq_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q <= '0;
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLASH_BASE: flash_base_q <= cfg_wdata;
				REG_POLL_LIMIT: poll_limit_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign full = jq_full;

	nfcs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.jq_full        (jq_full),
		.operation      (operation),
		.target_address (target_address),
		.write_data     (write_data),
		.read_data      (read_data),
		.flash_base     (flash_base_q),
		.poll_limit     (poll_limit_q),
		.job_push       (job_push),
		.job            (job_in)
	);

	nfcs_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wjob   (job_in),
		.full   (jq_full),
		.pop    (jq_pop),
		.rjob   (job_out),
		.empty  (jq_empty)
	);

	nfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.flash_base (flash_base_q),
		.jq_job     (job_out),
		.jq_empty   (jq_empty),
		.jq_pop     (jq_pop),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign cycle_kind = res.kind;
	assign bus_address = res.addr;
	assign bus_data = res.data;
	assign status = res.status;
	assign last = res.last;

endmodule

`default_nettype wire
